### rtl/tsq_pkg.sv
// tsq_pkg: shared types and constants for the touch sample qualifier
// request and result structs, action codes, register indexes and sequencer states
// no dependencies
package tsq_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int SAMPLE_LSB = 3;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 3;
	localparam int DIV_STEPS  = 32;
	localparam int DIV_CNT_W  = 5;
	localparam int ROUND_ADD  = 2047;
	localparam int P_SHIFT    = 17;
	localparam int MOVE_MIN   = 5;

	localparam logic [SAMPLE_W-1:0] X_OPEN = (1 << SAMPLE_W) - 1;

	localparam logic [2:0] ACT_REPEAT  = 3'd0;
	localparam logic [2:0] ACT_NEXT    = 3'd1;
	localparam logic [2:0] ACT_REJECT  = 3'd2;
	localparam logic [2:0] ACT_DONE    = 3'd3;
	localparam logic [2:0] ACT_START   = 3'd4;
	localparam logic [2:0] ACT_RELEASE = 3'd5;
	localparam logic [2:0] ACT_IDLE    = 3'd6;

	localparam logic [1:0] COORD_Y  = 2'd0;
	localparam logic [1:0] COORD_X  = 2'd1;
	localparam logic [1:0] COORD_Z1 = 2'd2;
	localparam logic [1:0] COORD_Z2 = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_PLATES    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DB_LIMIT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DB_TOL    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DB_REPEAT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PLATE_OHM = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_P_LIMIT   = 3'd5;

	typedef struct packed {
		logic        mode;
		logic [15:0] raw_word;
		logic        pen_line;
	} sample_t;

	typedef struct packed {
		logic [2:0]          action;
		logic [1:0]          coord_index;
		logic                touch_event;
		logic                report_valid;
		logic [SAMPLE_W-1:0] pos_x;
		logic [SAMPLE_W-1:0] pos_y;
		logic [15:0]         pressure;
	} result_t;

	typedef enum logic [1:0] {
		DB_REPEAT,
		DB_ACCEPT,
		DB_ABANDON
	} db_code_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_PREP,
		S_MUL_X,
		S_MUL_P,
		S_DIV,
		S_ROUND,
		S_FIN,
		S_EMIT
	} state_t;

endpackage

### rtl/touch_sample_qualifier.sv
// touch_sample_qualifier: debounce, pressure and pen tracking for touch samples
// single module with sequencer, shared multiplier and iterative divider
// depends on tsq_pkg
//
// One request is taken at a time and yields exactly one result. A poll tick or a
// reply that does not complete a set passes through EVAL and EMIT, where it loads
// the result register; the block takes no new request until it is back in IDLE.
// A reply that completes a set in plate mode goes on from EVAL through PREP, two
// passes through the shared 32x16 multiplier (MUL_X, MUL_P), 32 steps of the
// restoring divider (one quotient bit per cycle), ROUND and FIN before EMIT. In
// two-coordinate mode, or when x (an open x reads as zero) or z1 is zero, a completing
// reply goes from PREP straight to FIN. The result register lets the next request
// be taken while the previous result is still stalled; a second result waits in the
// sequencer until the first one is taken.
module touch_sample_qualifier import tsq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	function automatic logic [SAMPLE_W-1:0] absdiff(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b
	);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	// configuration
	logic                plates_q;
	logic [7:0]          db_limit_q;
	logic [SAMPLE_W-1:0] db_tol_q;
	logic [7:0]          db_repeat_q;
	logic [15:0]         plate_ohm_q;
	logic [15:0]         p_limit_q;

	// control state
	state_t              state_q, state_nxt;
	logic [1:0]          coord_sel_q;
	logic [7:0]          read_cnt_q;
	logic [8:0]          cons_cnt_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic                touched_q;
	logic [SAMPLE_W-1:0] last_x_q;
	logic [SAMPLE_W-1:0] last_y_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                out_valid_q;

	// payload
	sample_t             item_q;
	logic [SAMPLE_W-1:0] coord_q [4];
	logic [31:0]         acc_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [15:0]         rt_q;
	result_t             res_q;
	result_t             out_q;

	logic                cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic                out_load;

	logic [SAMPLE_W-1:0] v;
	db_code_t            db_code;
	logic [7:0]          rc_nxt;
	logic [8:0]          cons_nxt;
	logic                prev_upd;
	logic [7:0]          lim_eff;
	logic [8:0]          cons_inc;
	logic                set_end;
	logic [2:0]          sel_inc;
	result_t             eval_res;

	logic [SAMPLE_W-1:0] x_f;
	logic                calc_needed;
	logic [15:0]         mul_b;
	logic [31:0]         prod;
	logic [SAMPLE_W:0]   rem_sh;
	logic [SAMPLE_W:0]   rem_diff;
	logic                q_bit;
	logic [32:0]         rnd_sum;
	logic                p_over;
	logic                moved;
	result_t             fin_res;

	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_PLATES:    prdata = {31'd0, plates_q};
			REG_DB_LIMIT:  prdata = {24'd0, db_limit_q};
			REG_DB_TOL:    prdata = {{(DATA_W-SAMPLE_W){1'b0}}, db_tol_q};
			REG_DB_REPEAT: prdata = {24'd0, db_repeat_q};
			REG_PLATE_OHM: prdata = {16'd0, plate_ohm_q};
			REG_P_LIMIT:   prdata = {16'd0, p_limit_q};
			default:       prdata = '0;
		endcase
	end

	// reply evaluation and debounce
	assign v        = item_q.raw_word[SAMPLE_LSB +: SAMPLE_W];
	assign lim_eff  = (db_limit_q < 8'd2) ? 8'd2 : db_limit_q;
	assign cons_inc = cons_cnt_q + 9'd1;
	assign sel_inc  = {1'b0, coord_sel_q} + 3'd1;
	assign set_end  = sel_inc >= (plates_q ? 3'd4 : 3'd2);

	always_comb begin
		db_code  = DB_ACCEPT;
		rc_nxt   = read_cnt_q;
		cons_nxt = cons_cnt_q;
		prev_upd = 1'b0;
		if (db_limit_q != 8'd0) begin
			if (read_cnt_q == 8'd0 || absdiff(prev_q, v) > db_tol_q) begin
				cons_nxt = '0;
				if (read_cnt_q < lim_eff) begin
					prev_upd = 1'b1;
					rc_nxt   = read_cnt_q + 8'd1;
					db_code  = DB_REPEAT;
				end else begin
					rc_nxt  = '0;
					db_code = DB_ABANDON;
				end
			end else if (cons_inc > {1'b0, db_repeat_q}) begin
				rc_nxt   = '0;
				cons_nxt = '0;
				db_code  = DB_ACCEPT;
			end else begin
				cons_nxt = cons_inc;
				rc_nxt   = (read_cnt_q == 8'hff) ? read_cnt_q : read_cnt_q + 8'd1;
				db_code  = DB_REPEAT;
			end
		end
	end

	always_comb begin
		eval_res = '0;
		if (item_q.mode) begin
			if (item_q.pen_line) begin
				eval_res.action = ACT_START;
			end else if (touched_q) begin
				eval_res.action = ACT_RELEASE;
			end else begin
				eval_res.action = ACT_IDLE;
			end
		end else begin
			case (db_code)
				DB_REPEAT: begin
					eval_res.action      = ACT_REPEAT;
					eval_res.coord_index = coord_sel_q;
				end
				DB_ABANDON: eval_res.action = ACT_REJECT;
				DB_ACCEPT: begin
					eval_res.action      = ACT_NEXT;
					eval_res.coord_index = sel_inc[1:0];
				end
				default: eval_res.action = ACT_REJECT;
			endcase
		end
	end

	// pressure datapath
	assign x_f         = (coord_q[COORD_X] == X_OPEN) ? '0 : coord_q[COORD_X];
	assign calc_needed = plates_q && (x_f != '0) && (coord_q[COORD_Z1] != '0);
	assign mul_b       = (state_q == S_MUL_X) ? {{(16-SAMPLE_W){1'b0}}, x_f} : plate_ohm_q;
	assign prod        = acc_q * {16'd0, mul_b};
	assign rem_sh      = {rem_q, acc_q[31]};
	assign rem_diff    = rem_sh - {1'b0, coord_q[COORD_Z1]};
	assign q_bit       = rem_sh >= {1'b0, coord_q[COORD_Z1]};
	assign rnd_sum     = {1'b0, acc_q} + 33'(ROUND_ADD);

	assign p_over = rt_q > p_limit_q;
	assign moved  = (absdiff(x_f, last_x_q) > SAMPLE_W'(MOVE_MIN))
		&& (absdiff(coord_q[COORD_Y], last_y_q) > SAMPLE_W'(MOVE_MIN));

	always_comb begin
		fin_res = '0;
		if (p_over) begin
			fin_res.action = ACT_REJECT;
		end else begin
			fin_res.action = ACT_DONE;
			if (rt_q != 16'd0) begin
				fin_res.touch_event = !touched_q;
				if (moved) begin
					fin_res.report_valid = 1'b1;
					fin_res.pos_x        = x_f;
					fin_res.pos_y        = coord_q[COORD_Y];
					fin_res.pressure     = rt_q;
				end
			end
		end
	end

	// sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (sample_valid) state_nxt = S_EVAL;
			S_EVAL: begin
				if (!item_q.mode && db_code == DB_ACCEPT && set_end) begin
					state_nxt = S_PREP;
				end else begin
					state_nxt = S_EMIT;
				end
			end
			S_PREP:  state_nxt = calc_needed ? S_MUL_X : S_FIN;
			S_MUL_X: state_nxt = S_MUL_P;
			S_MUL_P: state_nxt = S_DIV;
			S_DIV:   if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_ROUND;
			S_ROUND: state_nxt = S_FIN;
			S_FIN:   state_nxt = S_EMIT;
			S_EMIT:  if (!out_valid_q || !result_stall) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = state_q != S_IDLE;
		out_load     = (state_q == S_EMIT) && (!out_valid_q || !result_stall);
		result_valid = out_valid_q;
		result       = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plates_q    <= 1'b1;
			db_limit_q  <= '0;
			db_tol_q    <= '0;
			db_repeat_q <= '0;
			plate_ohm_q <= 16'd400;
			p_limit_q   <= 16'hffff;
			state_q     <= S_IDLE;
			coord_sel_q <= COORD_Y;
			read_cnt_q  <= '0;
			cons_cnt_q  <= '0;
			prev_q      <= '0;
			touched_q   <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr) begin
				case (cfg_idx)
					REG_PLATES:    plates_q    <= pwdata[0];
					REG_DB_LIMIT:  db_limit_q  <= pwdata[7:0];
					REG_DB_TOL:    db_tol_q    <= pwdata[SAMPLE_W-1:0];
					REG_DB_REPEAT: db_repeat_q <= pwdata[7:0];
					REG_PLATE_OHM: plate_ohm_q <= pwdata[15:0];
					REG_P_LIMIT:   p_limit_q   <= pwdata[15:0];
					default: ;
				endcase
			end
			if (state_q == S_EVAL) begin
				if (item_q.mode) begin
					if (item_q.pen_line) begin
						coord_sel_q <= COORD_Y;
					end else if (touched_q) begin
						touched_q <= 1'b0;
					end
				end else begin
					read_cnt_q <= rc_nxt;
					cons_cnt_q <= cons_nxt;
					if (prev_upd) prev_q <= v;
					if (db_code == DB_ABANDON) begin
						coord_sel_q <= COORD_Y;
					end else if (db_code == DB_ACCEPT) begin
						coord_sel_q <= set_end ? COORD_Y : sel_inc[1:0];
					end
				end
			end
			if (state_q == S_MUL_P) div_cnt_q <= '0;
			if (state_q == S_DIV) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (state_q == S_FIN && !p_over && rt_q != 16'd0) begin
				touched_q <= 1'b1;
				last_x_q  <= coord_q[COORD_X];
				last_y_q  <= coord_q[COORD_Y];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && sample_valid) item_q <= sample;
		case (state_q)
			S_EVAL: begin
				res_q <= eval_res;
				if (!item_q.mode && db_code == DB_ACCEPT) coord_q[coord_sel_q] <= v;
			end
			S_PREP: begin
				acc_q <= {{(32-SAMPLE_W){1'b0}}, coord_q[COORD_Z2]}
					- {{(32-SAMPLE_W){1'b0}}, coord_q[COORD_Z1]};
				if (!plates_q) begin
					rt_q <= {1'b0, p_limit_q[15:1]};
				end else begin
					rt_q <= '0;
				end
			end
			S_MUL_X: acc_q <= prod;
			S_MUL_P: begin
				acc_q <= prod;
				rem_q <= '0;
			end
			S_DIV: begin
				acc_q <= {acc_q[30:0], q_bit};
				rem_q <= q_bit ? rem_diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
			end
			S_ROUND: rt_q  <= {1'b0, rnd_sum[31:P_SHIFT]};
			S_FIN:   res_q <= fin_res;
			default: ;
		endcase
		if (out_load) out_q <= res_q;
	end

endmodule

### dv/testbench.sv
// testbench - self-checking bench for touch_sample_qualifier: directed sets, debounce and
// pressure cases, then random gestures under several register settings and idle patterns
// depends on tsq_pkg and rtl/touch_sample_qualifier.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tsq_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_stall;
	sample_t           sample;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int sender_idle_pct = 15;
	int receiver_idle_pct = 72;
	int requests_sent = 0;
	int mismatch_count = 0;

	// predicted block state and register copies
	logic                cfg_plates = 1'b1;
	logic [7:0]          cfg_db_limit = 8'd0;
	logic [11:0]         cfg_db_tol = 12'd0;
	logic [7:0]          cfg_db_repeats = 8'd0;
	logic [15:0]         cfg_plate_ohms = 16'd400;
	logic [15:0]         cfg_p_limit = 16'hffff;
	logic [1:0]          sel = COORD_Y;
	logic [SAMPLE_W-1:0] coords [4] = '{default: '0};
	int                  reads = 0;
	int                  agree_cnt = 0;
	logic [SAMPLE_W-1:0] prev_val = '0;
	logic                touched = 1'b0;
	logic [SAMPLE_W-1:0] last_x = '0;
	logic [SAMPLE_W-1:0] last_y = '0;

	result_t expected_results [$];
	result_t last_result;

	touch_sample_qualifier dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall = ($urandom_range(0, 99) < receiver_idle_pct);
	end

	function automatic int coord_distance(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
		return int'((a > b) ? a - b : b - a);
	endfunction

	function automatic db_code_t debounce_step(logic [SAMPLE_W-1:0] v);
		int lim;
		lim = int'(cfg_db_limit);
		if (lim == 0)
			return DB_ACCEPT;
		if (lim < 2)
			lim = 2;
		if (reads == 0 || coord_distance(prev_val, v) > cfg_db_tol) begin
			agree_cnt = 0;
			if (reads < lim) begin
				prev_val = v;
				reads++;
				return DB_REPEAT;
			end
			reads = 0;
			return DB_ABANDON;
		end
		agree_cnt++;
		if (agree_cnt > cfg_db_repeats) begin
			reads = 0;
			agree_cnt = 0;
			return DB_ACCEPT;
		end
		if (reads < 255)
			reads++;
		return DB_REPEAT;
	endfunction

	function automatic result_t predict_result(sample_t s);
		result_t             r;
		logic [SAMPLE_W-1:0] v;
		logic [SAMPLE_W-1:0] xr;
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] y;
		logic [31:0]         p;
		int                  count;
		r = '0;
		if (s.mode) begin
			if (s.pen_line) begin
				sel = COORD_Y;
				r.action = ACT_START;
			end else if (touched) begin
				touched = 1'b0;
				r.action = ACT_RELEASE;
			end else begin
				r.action = ACT_IDLE;
			end
			return r;
		end
		v = s.raw_word[SAMPLE_LSB +: SAMPLE_W];
		case (debounce_step(v))
			DB_REPEAT: begin
				r.action = ACT_REPEAT;
				r.coord_index = sel;
			end
			DB_ABANDON: begin
				sel = COORD_Y;
				r.action = ACT_REJECT;
			end
			default: begin
				coords[sel] = v;
				count = cfg_plates ? 4 : 2;
				if (int'(sel) + 1 < count) begin
					sel = sel + 2'd1;
					r.action = ACT_NEXT;
					r.coord_index = sel;
				end else begin
					sel = COORD_Y;
					y = coords[COORD_Y];
					xr = coords[COORD_X];
					x = (xr == X_OPEN) ? '0 : xr;
					p = '0;
					if (!cfg_plates) begin
						p = {16'd0, cfg_p_limit} >> 1;
					end else if (x != 0 && coords[COORD_Z1] != 0) begin
						// 32-bit wrapping arithmetic throughout
						p = 32'(coords[COORD_Z2]) - 32'(coords[COORD_Z1]);
						p = p * 32'(x);
						p = p * 32'(cfg_plate_ohms);
						p = p / 32'(coords[COORD_Z1]);
						p = (p + 32'(ROUND_ADD)) >> P_SHIFT;
					end
					if (p > cfg_p_limit) begin
						r.action = ACT_REJECT;
					end else begin
						r.action = ACT_DONE;
						if (p != 0) begin
							if (!touched) begin
								r.touch_event = 1'b1;
								touched = 1'b1;
							end
							if (coord_distance(x, last_x) > MOVE_MIN &&
									coord_distance(y, last_y) > MOVE_MIN) begin
								r.report_valid = 1'b1;
								r.pos_x = x;
								r.pos_y = y;
								r.pressure = p[15:0];
							end
							last_x = xr;
							last_y = y;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic sample_t reply_of(logic [SAMPLE_W-1:0] v);
		sample_t s;
		s.mode = 1'b0;
		s.raw_word = {1'($urandom), v, 3'($urandom)};
		s.pen_line = 1'($urandom);
		return s;
	endfunction

	function automatic sample_t tick_of(logic pen);
		sample_t s;
		s.mode = 1'b1;
		s.raw_word = 16'($urandom);
		s.pen_line = pen;
		return s;
	endfunction

	task automatic send_request(input sample_t s);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample = s;
		sample_valid = 1'b1;
		do @(posedge clk); while (sample_stall !== 1'b0);
		last_result = predict_result(s);
		expected_results.push_back(last_result);
		requests_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		sample_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_PLATES:    cfg_plates = value[0];
			REG_DB_LIMIT:  cfg_db_limit = value[7:0];
			REG_DB_TOL:    cfg_db_tol = value[11:0];
			REG_DB_REPEAT: cfg_db_repeats = value[7:0];
			REG_PLATE_OHM: cfg_plate_ohms = value[15:0];
			REG_P_LIMIT:   cfg_p_limit = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with no request outstanding: action %0d", result.action);
			end else begin
				want = expected_results.pop_front();
				check_field("action", 32'(want.action), 32'(result.action));
				check_field("coord_index", 32'(want.coord_index), 32'(result.coord_index));
				check_field("touch_event", 32'(want.touch_event), 32'(result.touch_event));
				check_field("report_valid", 32'(want.report_valid), 32'(result.report_valid));
				check_field("pos_x", 32'(want.pos_x), 32'(result.pos_x));
				check_field("pos_y", 32'(want.pos_y), 32'(result.pos_y));
				check_field("pressure", 32'(want.pressure), 32'(result.pressure));
			end
		end
	end

	// ticks, and a reply arriving outside a cycle
	task automatic test_poll_ticks();
		send_request(tick_of(1'b0));
		send_request(sample_t'{mode: 1'b0, raw_word: 16'h0000, pen_line: 1'b0});
		send_request(tick_of(1'b1));
	endtask

	// plate-mode sets: normal press, open x and zero z1, then pen release
	task automatic test_plate_sets();
		send_request(reply_of(12'd100));
		send_request(reply_of(12'd2000));
		send_request(reply_of(12'd1000));
		send_request(reply_of(12'd2000));
		send_request(tick_of(1'b1));
		send_request(sample_t'{mode: 1'b0, raw_word: 16'hffff, pen_line: 1'b1});
		send_request(reply_of(X_OPEN));
		send_request(reply_of(12'd0));
		send_request(reply_of(12'd4095));
		send_request(tick_of(1'b0));
	endtask

	// switch to two-coordinate mode while the set sits on z1
	task automatic test_mode_change_mid_set();
		send_request(tick_of(1'b1));
		send_request(reply_of(12'd50));
		send_request(reply_of(12'd60));
		wait_for_results();
		write_register(REG_PLATES, 32'd0);
		send_request(reply_of(12'd3000));
	endtask

	// limit of one acts as two; accept after repeats, abandon after too many reads
	task automatic test_debounce();
		wait_for_results();
		write_register(REG_DB_LIMIT, 32'd1);
		write_register(REG_DB_TOL, 32'd10);
		write_register(REG_DB_REPEAT, 32'd1);
		send_request(tick_of(1'b1));
		send_request(reply_of(12'd500));
		send_request(reply_of(12'd505));
		send_request(reply_of(12'd507));
		send_request(reply_of(12'd100));
		send_request(reply_of(12'd3000));
		send_request(reply_of(12'd10));
	endtask

	task automatic test_pressure_limit();
		wait_for_results();
		write_register(REG_PLATES, 32'd1);
		write_register(REG_DB_LIMIT, 32'd0);
		write_register(REG_P_LIMIT, 32'd3);
		send_request(tick_of(1'b1));
		send_request(reply_of(12'd100));
		send_request(reply_of(12'd2000));
		send_request(reply_of(12'd1000));
		send_request(reply_of(12'd2000));
	endtask

	function automatic logic [SAMPLE_W-1:0] fresh_value(logic [1:0] idx);
		if (idx == COORD_X && $urandom_range(0, 9) == 0)
			return X_OPEN;
		if (idx == COORD_Z1 && $urandom_range(0, 9) == 0)
			return '0;
		return SAMPLE_W'($urandom);
	endfunction

	function automatic logic [SAMPLE_W-1:0] wander(logic [SAMPLE_W-1:0] v);
		int t;
		int d;
		if ($urandom_range(0, 7) == 0)
			return SAMPLE_W'($urandom);
		t = int'(v);
		d = int'($urandom_range(0, cfg_db_tol));
		if ($urandom_range(0, 1))
			t += d;
		else
			t -= d;
		if (t < 0)
			t = 0;
		if (t > 4095)
			t = 4095;
		return SAMPLE_W'(t);
	endfunction

	task automatic run_gesture();
		int roll;
		int replies;
		logic [SAMPLE_W-1:0] level;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			send_request(tick_of(1'b0));
		end else if (roll < 16) begin
			send_request(reply_of(SAMPLE_W'($urandom)));
		end else if (roll < 19) begin
			wait_for_results();
		end else begin
			send_request(tick_of(1'b1));
			level = fresh_value(COORD_Y);
			for (replies = 0; replies < 60; replies++) begin
				send_request(reply_of(level));
				if (last_result.action == ACT_NEXT)
					level = fresh_value(last_result.coord_index);
				else if (last_result.action != ACT_REPEAT)
					break;
				else
					level = wander(level);
			end
		end
	endtask

	task automatic test_random_traffic();
		int phase;
		int k;
		int target;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 15;
					receiver_idle_pct = 72;
				end
				1: begin
					sender_idle_pct = 72;
					receiver_idle_pct = 15;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (k = 0; k < 4; k++) begin
				wait_for_results();
				case (k)
					0: begin
						write_register(REG_PLATES, 32'd1);
						write_register(REG_DB_LIMIT, 32'd0);
						write_register(REG_DB_TOL, 32'd0);
						write_register(REG_DB_REPEAT, 32'd255);
						write_register(REG_PLATE_OHM, 32'd65535);
						write_register(REG_P_LIMIT, 32'd65535);
					end
					1: begin
						write_register(REG_PLATES, 32'd0);
						write_register(REG_DB_LIMIT, 32'd1);
						write_register(REG_DB_TOL, 32'd4095);
						write_register(REG_DB_REPEAT, 32'd0);
						write_register(REG_PLATE_OHM, 32'd0);
						write_register(REG_P_LIMIT, 32'd0);
					end
					2: begin
						write_register(REG_PLATES, 32'd1);
						write_register(REG_DB_LIMIT, 32'd255);
						write_register(REG_DB_TOL, $urandom_range(0, 60));
						write_register(REG_DB_REPEAT, $urandom_range(0, 3));
						write_register(REG_PLATE_OHM, 32'd400);
						write_register(REG_P_LIMIT, $urandom_range(0, 65535));
					end
					default: begin
						write_register(REG_PLATES, $urandom_range(0, 1));
						write_register(REG_DB_LIMIT, $urandom_range(2, 6));
						write_register(REG_DB_TOL, $urandom_range(0, 4095));
						write_register(REG_DB_REPEAT, $urandom_range(0, 3));
						write_register(REG_PLATE_OHM, $urandom_range(0, 65535));
						write_register(REG_P_LIMIT, $urandom_range(0, 65535));
					end
				endcase
				target = requests_sent + 36;
				while (requests_sent < target)
					run_gesture();
			end
		end
	endtask

	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_poll_ticks();
		test_plate_sets();
		test_mode_change_mid_set();
		test_debounce();
		test_pressure_limit();
		test_random_traffic();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatch_count += expected_results.size();
		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
